[hw/rtl/wsp_pkg.sv]
// wsp_pkg: shared types, codes and the byte compare rule of the wildcard
// signature scanner. no dependencies.
`default_nettype none

package wsp_pkg;

    localparam logic [7:0] WILDCARD_BYTE = 8'hCC;
    localparam logic [7:0] LANG_BYTE     = 8'h0D;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;

    localparam logic [7:0] PATTERN_LENGTH_RESET = 8'd121;
    localparam logic [7:0] PATCH_VALUE_RESET    = 8'd13;

    // site counters saturate one above the largest emit limit
    localparam int unsigned CNT_W = 7;
    localparam logic [CNT_W-1:0] CNT_SAT = 7'd64;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_VALUE    = 2'd1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SCAN = 1'b1;

    typedef enum logic [1:0] {
        KIND_MATCH     = 2'd0,
        KIND_PATCH     = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } kind_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic       load;
        logic       shift;
        logic       first;
        logic [6:0] load_idx;
        logic [7:0] data;
    } cell_ctl_t;

    function automatic logic byte_match(input logic [7:0] pat, input logic [7:0] txt);
        logic hit;
        if (pat == WILDCARD_BYTE) begin
            hit = 1'b1;
        end else if (pat == LANG_BYTE && (txt == ZERO_BYTE || txt == LANG_BYTE)) begin
            hit = 1'b1;
        end else begin
            hit = (pat == txt);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/wsp_cell.sv]
// wsp_cell: one pattern position of the scan chain. holds the pattern byte,
// the partial match flag, the site count and one zero bit of the window.
// depends on wsp_pkg.
`default_nettype none

module wsp_cell
    import wsp_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_ctl_t        ctl,
    input  wire logic             d_prev,
    input  wire logic [CNT_W-1:0] cnt_prev,
    input  wire logic             zero_prev,
    output logic                  d_q,
    output logic [CNT_W-1:0]      cnt_q,
    output logic                  zero_q,
    output logic                  lang
);

    logic [7:0]       pat_reg;
    logic             d_reg;
    logic             d_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             zero_reg;
    logic             site;

    assign lang     = (pat_reg == LANG_BYTE);
    assign site     = lang & (ctl.data == ZERO_BYTE);
    assign d_next   = d_prev & byte_match(pat_reg, ctl.data);
    assign cnt_next = (cnt_prev == CNT_SAT) ? CNT_SAT : cnt_prev + CNT_W'(site);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg <= 1'b0;
        end else if (ctl.load) begin
            d_reg <= 1'b0;
        end else if (ctl.shift) begin
            d_reg <= d_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load && (32'(ctl.load_idx) == 32'(IDX))) begin
            pat_reg <= ctl.data;
        end
        if (ctl.shift) begin
            cnt_reg  <= cnt_next;
            zero_reg <= zero_prev;
        end
    end

    assign d_q    = d_reg;
    assign cnt_q  = cnt_reg;
    assign zero_q = zero_reg;

endmodule

`default_nettype wire

[hw/rtl/wsp_ctrl.sv]
// wsp_ctrl: transaction sequencer. drives the cell chain, checks the match
// tap, walks the pattern for patch sites and holds the output register.
// depends on wsp_pkg.
`default_nettype none

module wsp_ctrl
    import wsp_pkg::*;
#(
    parameter int PATTERN_MAX     = 128,
    parameter int OFFSET_BITS     = 24,
    parameter int MAX_PATCH_SITES = 63
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_action,
    input  wire logic [6:0]             s_pattern_index,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic                   s_end_of_region,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_kind,
    output logic [OFFSET_BITS-1:0]      m_offset,
    output logic [7:0]                  m_write_value,
    output logic                        m_overflow,
    output logic                        m_last,
    input  wire logic [7:0]             pattern_length,
    input  wire logic [7:0]             patch_value,
    output cell_ctl_t                   cell_ctl,
    input  wire logic [PATTERN_MAX-1:0] d_vec,
    input  wire logic [PATTERN_MAX-1:0] lang_vec,
    input  wire logic [PATTERN_MAX-1:0] zero_vec,
    input  wire logic [CNT_W-1:0]       cnt_arr [PATTERN_MAX]
);

    localparam int IDX_W = $clog2(PATTERN_MAX);
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_PATCH
    } state_t;

    state_t                 state_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] start_reg;
    logic                   match_done_reg;
    logic                   eor_reg;
    logic                   scanned_reg;
    logic                   ovf_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       emitted_reg;
    logic [CNT_W-1:0]       total_reg;
    logic                   m_valid_reg;
    kind_t                  kind_reg;
    logic [OFFSET_BITS-1:0] m_offset_reg;
    logic [7:0]             value_reg;
    logic                   m_ovf_reg;
    logic                   m_last_reg;

    logic [LEN_W-1:0] len_eff;
    logic [IDX_W-1:0] tap;
    logic [IDX_W-1:0] zero_tap;
    logic [CNT_W-1:0] cnt_sel;
    logic             ovf_sel;
    logic [CNT_W-1:0] total_sel;
    logic             hit;
    logic             site;
    logic             out_free;
    logic             accept;
    logic             patch_last;

    always_comb begin
        if (pattern_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(pattern_length) > PATTERN_MAX) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = LEN_W'(pattern_length);
        end
    end

    assign tap        = IDX_W'(len_eff - LEN_W'(1));
    assign zero_tap   = IDX_W'(len_eff - LEN_W'(1) - LEN_W'(idx_reg));
    assign cnt_sel    = cnt_arr[tap];
    assign ovf_sel    = (cnt_sel > CNT_W'(MAX_PATCH_SITES));
    assign total_sel  = ovf_sel ? CNT_W'(MAX_PATCH_SITES) : cnt_sel;
    assign hit        = scanned_reg & ~match_done_reg & d_vec[tap];
    assign site       = lang_vec[idx_reg] & zero_vec[zero_tap];
    assign out_free   = ~m_valid_reg | m_ready;
    assign patch_last = (emitted_reg + CNT_W'(1) == total_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid & s_ready;

    assign cell_ctl.load     = accept & (s_action == ACT_LOAD);
    assign cell_ctl.shift    = accept & (s_action == ACT_SCAN) & (offset_reg != '1);
    assign cell_ctl.first    = (offset_reg == '0);
    assign cell_ctl.load_idx = s_pattern_index;
    assign cell_ctl.data     = s_data_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            offset_reg     <= '0;
            match_done_reg <= 1'b0;
            eor_reg        <= 1'b0;
            scanned_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cell_ctl.load) begin
                        offset_reg     <= '0;
                        match_done_reg <= 1'b0;
                    end else if (accept) begin
                        if (cell_ctl.shift) begin
                            offset_reg <= offset_reg + OFFSET_BITS'(1);
                        end
                        scanned_reg <= cell_ctl.shift;
                        eor_reg     <= s_end_of_region;
                        state_reg   <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (hit) begin
                        if (out_free) begin
                            m_valid_reg    <= 1'b1;
                            kind_reg       <= KIND_MATCH;
                            m_offset_reg   <= offset_reg - OFFSET_BITS'(len_eff);
                            value_reg      <= '0;
                            m_ovf_reg      <= ovf_sel;
                            m_last_reg     <= (total_sel == '0);
                            start_reg      <= offset_reg - OFFSET_BITS'(len_eff);
                            total_reg      <= total_sel;
                            ovf_reg        <= ovf_sel;
                            emitted_reg    <= '0;
                            idx_reg        <= '0;
                            match_done_reg <= 1'b1;
                            if (total_sel == '0) begin
                                state_reg <= S_IDLE;
                                if (eor_reg) begin
                                    offset_reg     <= '0;
                                    match_done_reg <= 1'b0;
                                end
                            end else begin
                                state_reg <= S_PATCH;
                            end
                        end
                    end else if (eor_reg && !match_done_reg) begin
                        if (out_free) begin
                            m_valid_reg  <= 1'b1;
                            kind_reg     <= KIND_NOT_FOUND;
                            m_offset_reg <= '0;
                            value_reg    <= '0;
                            m_ovf_reg    <= 1'b0;
                            m_last_reg   <= 1'b1;
                            offset_reg   <= '0;
                            state_reg    <= S_IDLE;
                        end
                    end else begin
                        if (eor_reg) begin
                            offset_reg     <= '0;
                            match_done_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_PATCH: begin
                    if (!site) begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end else if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        kind_reg     <= KIND_PATCH;
                        m_offset_reg <= start_reg + OFFSET_BITS'(idx_reg);
                        value_reg    <= patch_value;
                        m_ovf_reg    <= ovf_reg;
                        m_last_reg   <= patch_last;
                        emitted_reg  <= emitted_reg + CNT_W'(1);
                        idx_reg      <= idx_reg + IDX_W'(1);
                        if (patch_last) begin
                            state_reg <= S_IDLE;
                            if (eor_reg) begin
                                offset_reg     <= '0;
                                match_done_reg <= 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_offset      = m_offset_reg;
    assign m_write_value = value_reg;
    assign m_overflow    = m_ovf_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

[hw/rtl/wildcard_signature_scan_patch.sv]
// wildcard_signature_scan_patch: top level. configuration registers, the
// chain of PATTERN_MAX scan cells and the sequencer. depends on wsp_pkg,
// wsp_cell and wsp_ctrl.
// a pattern load is taken while idle; a text byte goes to the check state,
// which registers its match or not-found result. after a match the sequencer
// walks one pattern position per cycle, up to the effective pattern length,
// pausing at sites while the output is full; one patch write per site found,
// up to MAX_PATCH_SITES. reset clears control state and sets pattern_length
// to 121 and patch_value to 13; pattern bytes are undefined until loaded
`default_nettype none

module wildcard_signature_scan_patch
    import wsp_pkg::*;
#(
    parameter int PATTERN_MAX     = 128,
    parameter int OFFSET_BITS     = 24,
    parameter int MAX_PATCH_SITES = 63
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_action,
    input  wire logic [6:0]             s_pattern_index,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic                   s_end_of_region,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_kind,
    output logic [OFFSET_BITS-1:0]      m_offset,
    output logic [7:0]                  m_write_value,
    output logic                        m_overflow,
    output logic                        m_last,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]             cfg_data
);

    logic [7:0] pattern_length_reg;
    logic [7:0] patch_value_reg;

    cell_ctl_t              cell_ctl;
    logic [PATTERN_MAX-1:0] d_vec;
    logic [PATTERN_MAX-1:0] lang_vec;
    logic [PATTERN_MAX-1:0] zero_vec;
    logic [CNT_W-1:0]       cnt_arr [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] d_in;
    logic [PATTERN_MAX-1:0] zero_in;
    logic [CNT_W-1:0]       cnt_in [PATTERN_MAX];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= PATTERN_LENGTH_RESET;
            patch_value_reg    <= PATCH_VALUE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data;
                REG_PATCH_VALUE:    patch_value_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign d_in[i]    = 1'b1;
            assign cnt_in[i]  = '0;
            assign zero_in[i] = (cell_ctl.data == ZERO_BYTE);
        end else begin : g_link
            assign d_in[i]    = d_vec[i-1] & ~cell_ctl.first;
            assign cnt_in[i]  = cell_ctl.first ? '0 : cnt_arr[i-1];
            assign zero_in[i] = zero_vec[i-1];
        end

        wsp_cell #(
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (cell_ctl),
            .d_prev    (d_in[i]),
            .cnt_prev  (cnt_in[i]),
            .zero_prev (zero_in[i]),
            .d_q       (d_vec[i]),
            .cnt_q     (cnt_arr[i]),
            .zero_q    (zero_vec[i]),
            .lang      (lang_vec[i])
        );
    end

    wsp_ctrl #(
        .PATTERN_MAX     (PATTERN_MAX),
        .OFFSET_BITS     (OFFSET_BITS),
        .MAX_PATCH_SITES (MAX_PATCH_SITES)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_pattern_index (s_pattern_index),
        .s_data_byte     (s_data_byte),
        .s_end_of_region (s_end_of_region),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_offset        (m_offset),
        .m_write_value   (m_write_value),
        .m_overflow      (m_overflow),
        .m_last          (m_last),
        .pattern_length  (pattern_length_reg),
        .patch_value     (patch_value_reg),
        .cell_ctl        (cell_ctl),
        .d_vec           (d_vec),
        .lang_vec        (lang_vec),
        .zero_vec        (zero_vec),
        .cnt_arr         (cnt_arr)
    );

endmodule

`default_nettype wire

[tb/wsp_scan_checker.sv]
`timescale 1ns / 1ps
// wsp_scan_checker: watches the input, config and result channels of the
// wildcard signature scanner, predicts every result and compares it field by field.
// depends on wsp_pkg.

module wsp_scan_checker
    import wsp_pkg::*;
#(
    parameter int PATTERN_MAX     = 128,
    parameter int OFFSET_BITS     = 24,
    parameter int MAX_PATCH_SITES = 63
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_action,
    input  logic [6:0]             s_pattern_index,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_end_of_region,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [1:0]             m_kind,
    input  logic [OFFSET_BITS-1:0] m_offset,
    input  logic [7:0]             m_write_value,
    input  logic                   m_overflow,
    input  logic                   m_last,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]             cfg_data,
    output int unsigned            outstanding,
    output int unsigned            fail_count
);

    typedef struct packed {
        kind_t                  kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [7:0]             value;
        logic                   overflow;
        logic                   last;
    } scan_result_t;

    logic [7:0]             sig_bytes [PATTERN_MAX];
    logic [7:0]             recent [PATTERN_MAX];
    logic [OFFSET_BITS-1:0] region_pos;
    logic                   found;
    logic [7:0]             len_reg;
    logic [7:0]             pv_reg;
    scan_result_t           due_results [$];
    int unsigned            n_fail;

    assign fail_count = n_fail;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_fail++;
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic queue_result(input kind_t kind, input logic [OFFSET_BITS-1:0] ofs,
                                input logic [7:0] val, input logic ovf);
        scan_result_t r;
        r.kind     = kind;
        r.offset   = ofs;
        r.value    = val;
        r.overflow = ovf;
        r.last     = 1'b0;
        due_results.push_back(r);
    endtask

    task automatic predict_item(input logic act, input logic [6:0] idx,
                                input logic [7:0] data, input logic eor);
        int                     len;
        int                     base;
        int                     sites;
        int                     emitted;
        int                     depth0;
        int                     i;
        logic                   hit;
        logic                   ovf;
        logic [7:0]             p;
        logic [7:0]             t;
        logic [OFFSET_BITS-1:0] start;
        scan_result_t           r;
        depth0 = due_results.size();
        if (act == ACT_LOAD) begin
            sig_bytes[idx] = data;
            region_pos = '0;
            found = 1'b0;
        end else begin
            // a byte arriving at the all-ones offset is not scanned
            if (region_pos != '1) begin
                if (len_reg == 8'd0) begin
                    len = 1;
                end else if (int'(len_reg) > PATTERN_MAX) begin
                    len = PATTERN_MAX;
                end else begin
                    len = int'(len_reg);
                end
                for (i = 0; i < PATTERN_MAX - 1; i++) begin
                    recent[i] = recent[i+1];
                end
                recent[PATTERN_MAX-1] = data;
                region_pos = region_pos + 1'b1;
                if (!found && int'(region_pos) >= len) begin
                    base = PATTERN_MAX - len;
                    hit = 1'b1;
                    sites = 0;
                    for (i = 0; i < len; i++) begin
                        p = sig_bytes[i];
                        t = recent[base+i];
                        if (!(p == WILDCARD_BYTE || p == t ||
                              (p == LANG_BYTE && (t == ZERO_BYTE || t == LANG_BYTE)))) begin
                            hit = 1'b0;
                        end
                        if (p == LANG_BYTE && t == ZERO_BYTE) begin
                            sites++;
                        end
                    end
                    if (hit) begin
                        found = 1'b1;
                        ovf = (sites > MAX_PATCH_SITES);
                        start = region_pos - OFFSET_BITS'(len);
                        queue_result(KIND_MATCH, start, 8'h00, ovf);
                        emitted = 0;
                        for (i = 0; i < len; i++) begin
                            if (sig_bytes[i] == LANG_BYTE && recent[base+i] == ZERO_BYTE &&
                                emitted < MAX_PATCH_SITES) begin
                                queue_result(KIND_PATCH, start + OFFSET_BITS'(i), pv_reg, ovf);
                                emitted++;
                            end
                        end
                    end
                end
            end
            if (eor) begin
                if (!found) begin
                    queue_result(KIND_NOT_FOUND, '0, 8'h00, 1'b0);
                end
                region_pos = '0;
                found = 1'b0;
            end
        end
        if (due_results.size() > depth0) begin
            r = due_results.pop_back();
            r.last = 1'b1;
            due_results.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        scan_result_t want;
        if (!aresetn) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                sig_bytes[k] = 8'h00;
                recent[k] = 8'h00;
            end
            region_pos = '0;
            found = 1'b0;
            len_reg = PATTERN_LENGTH_RESET;
            pv_reg = PATCH_VALUE_RESET;
            due_results.delete();
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with none expected, offset", 32'(m_offset), 0);
                end else begin
                    want = due_results.pop_front();
                    if (m_kind != want.kind) begin
                        report_mismatch("kind", 32'(m_kind), 32'(want.kind));
                    end
                    if (m_offset != want.offset) begin
                        report_mismatch("offset", 32'(m_offset), 32'(want.offset));
                    end
                    if (m_write_value != want.value) begin
                        report_mismatch("write_value", 32'(m_write_value), 32'(want.value));
                    end
                    if (m_overflow != want.overflow) begin
                        report_mismatch("overflow", 32'(m_overflow), 32'(want.overflow));
                    end
                    if (m_last != want.last) begin
                        report_mismatch("last", 32'(m_last), 32'(want.last));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_PATTERN_LENGTH) begin
                    len_reg = cfg_data;
                end else if (cfg_index == REG_PATCH_VALUE) begin
                    pv_reg = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                predict_item(s_action, s_pattern_index, s_data_byte, s_end_of_region);
            end
            outstanding <= due_results.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: stimulus and verdict for wildcard_signature_scan_patch. drives pattern loads,
// text regions and register writes; depends on wsp_pkg and wsp_scan_checker.

module tb;
    import wsp_pkg::*;

    localparam int PATTERN_MAX     = 128;
    localparam int OFFSET_BITS     = 24;
    localparam int MAX_PATCH_SITES = 63;
    localparam int TOTAL_ITEMS     = 470;
    localparam int DRAIN_CYCLES    = PATTERN_MAX + 16;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef enum int {RG_EMBED, RG_BROKEN, RG_SHORT, RG_NOISE} region_kind_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_action;
    logic [6:0]             s_pattern_index;
    logic [7:0]             s_data_byte;
    logic                   s_end_of_region;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_kind;
    logic [OFFSET_BITS-1:0] m_offset;
    logic [7:0]             m_write_value;
    logic                   m_overflow;
    logic                   m_last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [7:0]             cfg_data;
    int unsigned            outstanding;
    int unsigned            fail_count;

    logic [7:0]  sig_img [PATTERN_MAX];
    bit          sig_set [PATTERN_MAX];
    int          eff_len;
    int unsigned sent_items;
    int unsigned idle_cycles;
    int unsigned hold_cnt;
    logic        quiet;

    wildcard_signature_scan_patch #(
        .PATTERN_MAX(PATTERN_MAX), .OFFSET_BITS(OFFSET_BITS), .MAX_PATCH_SITES(MAX_PATCH_SITES)
    ) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_pattern_index(s_pattern_index), .s_data_byte(s_data_byte),
        .s_end_of_region(s_end_of_region),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_offset(m_offset),
        .m_write_value(m_write_value), .m_overflow(m_overflow), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    wsp_scan_checker #(
        .PATTERN_MAX(PATTERN_MAX), .OFFSET_BITS(OFFSET_BITS), .MAX_PATCH_SITES(MAX_PATCH_SITES)
    ) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_pattern_index(s_pattern_index), .s_data_byte(s_data_byte),
        .s_end_of_region(s_end_of_region),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_offset(m_offset),
        .m_write_value(m_write_value), .m_overflow(m_overflow), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .outstanding(outstanding), .fail_count(fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int stall_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // receiver back-pressure
    always @(posedge aclk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            hold_cnt <= stall_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL wildcard_signature_scan_patch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_text();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5) return ZERO_BYTE;
        if (r < 7) return LANG_BYTE;
        if (r < 8) return WILDCARD_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_sig_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return WILDCARD_BYTE;
        if (r < 6) return LANG_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] fit_byte(input logic [7:0] p, input int zero_pct);
        if (p == WILDCARD_BYTE) return rand_text();
        if (p == LANG_BYTE) return ($urandom_range(1, 100) <= zero_pct) ? ZERO_BYTE : LANG_BYTE;
        return p;
    endfunction

    task automatic send_item(input logic act, input logic [6:0] idx, input logic [7:0] data,
                             input logic eor);
        int gap;
        s_valid <= 1'b1;
        s_action <= act;
        s_pattern_index <= idx;
        s_data_byte <= data;
        s_end_of_region <= eor;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (act == ACT_LOAD) begin
            sig_img[idx] = data;
            sig_set[idx] = 1'b1;
        end
        sent_items++;
        gap = (quiet || $urandom_range(0, 9) < 6) ? 0 : stall_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic scan_byte(input logic [7:0] data, input logic eor);
        send_item(ACT_SCAN, 7'($urandom_range(0, 127)), data, eor);
    endtask

    // hold the sender until every pending result is out and the patch walk is over
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_regs(input bit set_len, input logic [7:0] len_raw,
                                input bit set_val, input logic [7:0] val);
        if (set_len) begin
            cfg_write(REG_PATTERN_LENGTH, len_raw);
            eff_len = (len_raw == 8'd0) ? 1 : ((int'(len_raw) > PATTERN_MAX) ?
                      PATTERN_MAX : int'(len_raw));
        end
        if (set_val) begin
            cfg_write(REG_PATCH_VALUE, val);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_missing();
        int i;
        for (i = 0; i < eff_len; i++) begin
            if (!sig_set[i]) begin
                send_item(ACT_LOAD, 7'(i), rand_sig_byte(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic run_region(input region_kind_t rk, input int pre_max, input int zero_pct);
        logic [7:0] seq [$];
        logic [7:0] v;
        int         pre;
        int         cut;
        int         k;
        int         i;
        pre = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, pre_max);
        for (i = 0; i < pre; i++) begin
            seq.push_back(rand_text());
        end
        if (rk == RG_NOISE) begin
            cut = $urandom_range(1, 12);
            for (i = 0; i < cut; i++) begin
                seq.push_back(rand_text());
            end
        end else begin
            cut = (rk == RG_SHORT) ? $urandom_range(0, eff_len - 1) : eff_len;
            for (i = 0; i < cut; i++) begin
                seq.push_back(fit_byte(sig_img[i], zero_pct));
            end
            if (rk == RG_BROKEN) begin
                k = $urandom_range(0, eff_len - 1);
                for (i = 0; i < eff_len && sig_img[k] == WILDCARD_BYTE; i++) begin
                    k = (k + 1) % eff_len;
                end
                if (sig_img[k] == LANG_BYTE) begin
                    v = 8'($urandom_range(1, 255));
                    if (v == LANG_BYTE) v = 8'h0E;
                    seq[pre+k] = v;
                end else if (sig_img[k] != WILDCARD_BYTE) begin
                    seq[pre+k] = sig_img[k] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            if (rk != RG_SHORT) begin
                cut = $urandom_range(0, 4);
                for (i = 0; i < cut; i++) begin
                    seq.push_back(rand_text());
                end
            end
        end
        if (seq.size() == 0) begin
            seq.push_back(rand_text());
        end
        for (i = 0; i < seq.size(); i++) begin
            scan_byte(seq[i], i == seq.size() - 1);
        end
    endtask

    initial begin
        int          i;
        int          r;
        int          n_regions;
        region_kind_t rk;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_action <= ACT_LOAD;
        s_pattern_index <= '0;
        s_data_byte <= '0;
        s_end_of_region <= 1'b0;
        m_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data <= '0;
        quiet <= 1'b0;
        hold_cnt = 0;
        idle_cycles = 0;
        sent_items = 0;
        eff_len = int'(PATTERN_LENGTH_RESET);
        for (i = 0; i < PATTERN_MAX; i++) begin
            sig_set[i] = 1'b0;
            sig_img[i] = 8'h00;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single-byte signatures, lang sites, wildcard, length extremes
        program_regs(1'b1, 8'd1, 1'b1, 8'h00);
        send_item(ACT_LOAD, 7'd0, LANG_BYTE, 1'b1);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b1);
        scan_byte(LANG_BYTE, 1'b1);
        scan_byte(8'hFF, 1'b1);
        send_item(ACT_LOAD, 7'd0, WILDCARD_BYTE, 1'b0);
        scan_byte(8'hA5, 1'b1);
        send_item(ACT_LOAD, 7'd0, 8'hFF, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b1);
        send_item(ACT_LOAD, 7'd127, 8'h00, 1'b0);
        settle();
        program_regs(1'b1, 8'd0, 1'b1, 8'hFF);
        scan_byte(8'hFF, 1'b1);
        settle();
        program_regs(1'b1, 8'd3, 1'b0, 8'h00);
        send_item(ACT_LOAD, 7'd1, LANG_BYTE, 1'b0);
        send_item(ACT_LOAD, 7'd2, WILDCARD_BYTE, 1'b0);
        send_item(ACT_LOAD, 7'd0, LANG_BYTE, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h77, 1'b1);
        scan_byte(8'h41, 1'b0);
        scan_byte(8'h00, 1'b1);

        // full-length signature under a clamped length, with too many patch sites
        settle();
        program_regs(1'b1, 8'd255, 1'b1, 8'($urandom_range(0, 255)));
        for (i = 0; i < PATTERN_MAX; i++) begin
            send_item(ACT_LOAD, 7'(i), (i % 17 == 5) ? WILDCARD_BYTE : LANG_BYTE,
                      1'($urandom_range(0, 1)));
        end
        run_region(RG_EMBED, 3, 100);

        while (sent_items < TOTAL_ITEMS) begin
            settle();
            quiet <= ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            program_regs($urandom_range(0, 3) != 0,
                         (r == 0) ? 8'd0 : ((r < 8) ? 8'($urandom_range(1, 8)) :
                                            8'($urandom_range(9, 24))),
                         $urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) != 0) begin
                for (i = 0; i < eff_len; i++) begin
                    send_item(ACT_LOAD, 7'(i), rand_sig_byte(), 1'($urandom_range(0, 1)));
                end
            end
            fill_missing();
            n_regions = $urandom_range(3, 8);
            for (i = 0; i < n_regions; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_item(ACT_LOAD, 7'($urandom_range(0, 127)), rand_sig_byte(),
                                  1'($urandom_range(0, 1)));
                    end else begin
                        scan_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    end
                end
                r = $urandom_range(0, 19);
                rk = (r < 11) ? RG_EMBED : ((r < 14) ? RG_BROKEN : ((r < 17) ? RG_SHORT : RG_NOISE));
                run_region(rk, 8, 70);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("PASS wildcard_signature_scan_patch");
        end else begin
            $display("FAIL wildcard_signature_scan_patch");
        end
        $finish;
    end

endmodule
